[rtl/rpg_pkg.sv]
// Shared types and constants of the ray proximity grasp tracker.
// Used by the multiply-accumulate lane and by the top level; depends on nothing.
package rpg_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SCORE_W = 7;
  localparam int TICK_W = 32;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [SCORE_W-1:0] SCORE_CAP = 7'd100;
  localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RESET = 7'd30;
  localparam logic [SCORE_W-1:0] SCORE_STEP_RESET = 7'd3;
  localparam logic [TICK_W-1:0] RELEASE_TICKS_RESET = 32'd1500;

  localparam int NTERMS = 4;
  localparam int NLANES = 4;

  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } mac_ctl_t;

endpackage

[rtl/ray_proximity_grasp_tracker_unit.sv]
// Ray proximity grasp tracker: top level with sequencer, state and result register.
// Depends on rpg_pkg and rpg_mac_lane.
//
// Usage: an item on the sample channel is either a pointer-ray sample with the
// object's own position (operation 0) or a time tick (operation 1). Each item
// gives exactly one result item with the grasp flag, the score, the score_rose
// flag and the setpoint origin + range * direction in signed fixed point.
// The block works on one item at a time; sample_stall is high while it is busy.
// Four bit-serial lanes do all products, one multiplier bit per cycle. A ray
// sample that is measured in full runs three passes (cross and dot products,
// sum of squares, setpoint) before its result is registered; when one axis is
// already too far the squares pass is skipped. A tick or a sample while grasped
// runs the setpoint pass only. The result sits in an output register, so the
// next item is taken while a result waits; a stalled result holds the block in
// its last cycle until it is taken. Synchronous reset clears the state and
// result_valid and restores the register defaults.
// Registers are written through cfg_write, cfg_index and cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
module ray_proximity_grasp_tracker_unit
  import rpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic                         operation,
  input  logic [TICK_W-1:0]            now_ticks,
  input  logic signed [COORD_BITS-1:0] ray_origin_x,
  input  logic signed [COORD_BITS-1:0] ray_origin_y,
  input  logic signed [COORD_BITS-1:0] ray_origin_z,
  input  logic signed [COORD_BITS-1:0] ray_dir_x,
  input  logic signed [COORD_BITS-1:0] ray_dir_y,
  input  logic signed [COORD_BITS-1:0] ray_dir_z,
  input  logic signed [COORD_BITS-1:0] own_x,
  input  logic signed [COORD_BITS-1:0] own_y,
  input  logic signed [COORD_BITS-1:0] own_z,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         is_grasped,
  output logic [SCORE_W-1:0]           score,
  output logic                         score_rose,
  output logic signed [COORD_BITS-1:0] setpoint_x,
  output logic signed [COORD_BITS-1:0] setpoint_y,
  output logic signed [COORD_BITS-1:0] setpoint_z
);

  localparam int CW = COORD_BITS;
  localparam int NW = COORD_BITS - 1;
  localparam int AW = COORD_BITS + 1;
  localparam int MW = COORD_BITS;
  localparam int PW = AW + MW + 4;
  localparam int QW = PW - FRAC_BITS;
  localparam int DW = (QW > NW) ? QW : NW;
  localparam int SW = ((QW > CW) ? QW : CW) + 1;
  localparam int CNT_W = $clog2(MW + 1);
  localparam int BACKUP_RANGE = ((2 ** FRAC_BITS) * 2 + 5) / 10;
  localparam int NEAR_RESET = ((2 ** FRAC_BITS) * 3 + 5) / 10;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CROSS = 3'd1;
  localparam logic [2:0] ST_NEAR = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_SETPT = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]             state;
  logic [CNT_W-1:0]       cnt;
  logic                   op_reg;
  logic [TICK_W-1:0]      now_reg;

  logic [NW-1:0]          near_distance;
  logic [SCORE_W-1:0]     score_threshold;
  logic [SCORE_W-1:0]     score_step;
  logic [TICK_W-1:0]      release_ticks;

  logic [SCORE_W-1:0]     score_reg;
  logic                   grasp_flag;
  logic [TICK_W-1:0]      last_time;
  logic [NW-1:0]          held_range;
  logic signed [CW-1:0]   last_origin [3];
  logic signed [CW-1:0]   last_dir [3];
  logic signed [AW-1:0]   vec [3];
  logic [NW-1:0]          mag [3];
  logic                   near_ok;
  logic [NW-1:0]          range_cand;
  logic                   rose_reg;

  logic signed [CW-1:0]   ray_origin [3];
  logic signed [CW-1:0]   ray_dir [3];
  logic signed [CW-1:0]   own_pos [3];

  mac_ctl_t               lane_ctl;
  logic signed [AW-1:0]   lane_a [NLANES][NTERMS];
  logic        [MW-1:0]   lane_m [NLANES][NTERMS];
  logic   [NTERMS-1:0]    lane_neg [NLANES];
  logic signed [PW-1:0]   lane_prod [NLANES];

  logic                   in_take;
  logic                   pass_state;
  logic                   pass_done;
  logic                   out_free;

  logic [PW-1:0]          c_abs [3];
  logic [PW-1:0]          c_mag [3];
  logic [2:0]             c_lt;
  logic [DW-1:0]          dot_q;
  logic                   dot_sat;

  logic [SCORE_W:0]       score_sum;
  logic [SCORE_W-1:0]     score_sat;
  logic                   near_now;
  logic [SCORE_W-1:0]     score_upd;
  logic                   rose_now;
  logic [TICK_W-1:0]      elapsed;
  logic                   expired;

  logic signed [QW-1:0]   sp_q [3];
  logic signed [SW-1:0]   sp_sum [3];
  logic signed [CW-1:0]   sp_out [3];

  assign ray_origin[0] = ray_origin_x;
  assign ray_origin[1] = ray_origin_y;
  assign ray_origin[2] = ray_origin_z;
  assign ray_dir[0] = ray_dir_x;
  assign ray_dir[1] = ray_dir_y;
  assign ray_dir[2] = ray_dir_z;
  assign own_pos[0] = own_x;
  assign own_pos[1] = own_y;
  assign own_pos[2] = own_z;

  assign sample_stall = (state != ST_IDLE);
  assign in_take = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  assign pass_state = (state == ST_CROSS) || (state == ST_SQUARE) || (state == ST_SETPT);
  assign pass_done = pass_state && (cnt == CNT_W'(MW));
  assign lane_ctl.load = pass_state && (cnt == '0);
  assign lane_ctl.step = pass_state && (cnt != '0);
  assign lane_ctl.last = (cnt == CNT_W'(MW));

  // Operand selection for each multiply pass.
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      for (int t = 0; t < NTERMS; t++) begin
        lane_a[l][t] = '0;
        lane_m[l][t] = '0;
      end
      lane_neg[l] = '0;
    end
    unique case (state)
      ST_CROSS: begin
        lane_a[0][0] = vec[1];
        lane_m[0][0] = last_dir[2];
        lane_a[0][1] = vec[2];
        lane_m[0][1] = last_dir[1];
        lane_neg[0][1] = 1'b1;
        lane_a[1][0] = vec[2];
        lane_m[1][0] = last_dir[0];
        lane_a[1][1] = vec[0];
        lane_m[1][1] = last_dir[2];
        lane_neg[1][1] = 1'b1;
        lane_a[2][0] = vec[0];
        lane_m[2][0] = last_dir[1];
        lane_a[2][1] = vec[1];
        lane_m[2][1] = last_dir[0];
        lane_neg[2][1] = 1'b1;
        for (int k = 0; k < 3; k++) begin
          lane_a[3][k] = vec[k];
          lane_m[3][k] = last_dir[k];
        end
      end
      ST_SQUARE: begin
        for (int k = 0; k < 3; k++) begin
          lane_a[0][k] = AW'(mag[k]);
          lane_m[0][k] = MW'(mag[k]);
        end
        lane_a[0][3] = AW'(near_distance);
        lane_m[0][3] = MW'(near_distance);
        lane_neg[0][3] = 1'b1;
      end
      ST_SETPT: begin
        for (int k = 0; k < 3; k++) begin
          lane_a[k][0] = AW'(last_dir[k]);
          lane_m[k][0] = MW'(held_range);
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    rpg_mac_lane #(
      .AW(AW),
      .MW(MW)
    ) u_lane (
      .clk(clk),
      .ctl(lane_ctl),
      .mcand(lane_a[g]),
      .mplier(lane_m[g]),
      .negate(lane_neg[g]),
      .product(lane_prod[g])
    );
  end

  // Distance and range evaluation after the cross and dot pass.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_abs[k] = lane_prod[k][PW-1] ? -lane_prod[k] : lane_prod[k];
      c_mag[k] = c_abs[k] >> FRAC_BITS;
      c_lt[k] = c_mag[k] < PW'(near_distance);
    end
  end

  assign dot_q = DW'(lane_prod[3][PW-1:FRAC_BITS]);
  assign dot_sat = dot_q > DW'({NW{1'b1}});

  assign score_sum = {1'b0, score_reg} + {1'b0, score_step};
  assign score_sat = (score_sum > {1'b0, SCORE_CAP}) ? SCORE_CAP : score_sum[SCORE_W-1:0];
  assign near_now = near_ok && lane_prod[0][PW-1];
  assign score_upd = near_now ? score_sat : score_reg;
  assign rose_now = near_now && (score_sat > score_reg);
  assign elapsed = now_reg - last_time;
  assign expired = grasp_flag && (elapsed > release_ticks);

  // Setpoint is the origin plus the floored product, saturated to the coordinate range.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sp_q[k] = $signed(lane_prod[k][PW-1:FRAC_BITS]);
      sp_sum[k] = SW'(sp_q[k]) + SW'(last_origin[k]);
      if ((&sp_sum[k][SW-1:CW-1]) || !(|sp_sum[k][SW-1:CW-1])) begin
        sp_out[k] = sp_sum[k][CW-1:0];
      end else if (sp_sum[k][SW-1]) begin
        sp_out[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sp_out[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_distance <= NW'(NEAR_RESET);
      score_threshold <= SCORE_THRESHOLD_RESET;
      score_step <= SCORE_STEP_RESET;
      release_ticks <= RELEASE_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NEAR_DISTANCE:   near_distance <= cfg_data[NW-1:0];
        CFG_SCORE_THRESHOLD: score_threshold <= cfg_data[SCORE_W-1:0];
        CFG_SCORE_STEP:      score_step <= cfg_data[SCORE_W-1:0];
        CFG_RELEASE_TICKS:   release_ticks <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      score_reg <= '0;
      grasp_flag <= 1'b0;
      last_time <= '0;
      held_range <= '0;
      rose_reg <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        last_origin[k] <= '0;
        last_dir[k] <= '0;
      end
    end else begin
      if (pass_state) begin
        cnt <= pass_done ? '0 : cnt + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            op_reg <= operation;
            now_reg <= now_ticks;
            if (operation == OP_SAMPLE) begin
              last_time <= now_ticks;
              for (int k = 0; k < 3; k++) begin
                last_origin[k] <= ray_origin[k];
                last_dir[k] <= ray_dir[k];
                vec[k] <= AW'(own_pos[k]) - AW'(ray_origin[k]);
              end
            end
            state <= ((operation == OP_SAMPLE) && !grasp_flag) ? ST_CROSS : ST_DECIDE;
          end
        end
        ST_CROSS: begin
          if (pass_done) begin
            state <= ST_NEAR;
          end
        end
        ST_NEAR: begin
          for (int k = 0; k < 3; k++) begin
            mag[k] <= c_mag[k][NW-1:0];
          end
          near_ok <= &c_lt;
          if (lane_prod[3][PW-1]) begin
            range_cand <= NW'(BACKUP_RANGE);
          end else if (dot_sat) begin
            range_cand <= '1;
          end else begin
            range_cand <= dot_q[NW-1:0];
          end
          state <= (&c_lt) ? ST_SQUARE : ST_DECIDE;
        end
        ST_SQUARE: begin
          if (pass_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (op_reg == OP_TICK) begin
            rose_reg <= 1'b0;
            if (expired) begin
              grasp_flag <= 1'b0;
              score_reg <= '0;
            end
          end else if (!grasp_flag) begin
            score_reg <= score_upd;
            rose_reg <= rose_now;
            if (score_upd > score_threshold) begin
              grasp_flag <= 1'b1;
              held_range <= range_cand;
            end
          end else begin
            rose_reg <= 1'b0;
          end
          state <= ST_SETPT;
        end
        ST_SETPT: begin
          if (pass_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      is_grasped <= grasp_flag;
      score <= score_reg;
      score_rose <= rose_reg;
      setpoint_x <= sp_out[0];
      setpoint_y <= sp_out[1];
      setpoint_z <= sp_out[2];
    end
  end

  assert property (@(posedge clk) disable iff (rst) score_reg <= SCORE_CAP)
    else $error("Score is above its cap.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(grasp_flag) |-> $past(state) == ST_DECIDE)
    else $error("Grasp latched outside the decision cycle.");

  assert property (@(posedge clk) disable iff (rst)
    $fell(grasp_flag) |-> score_reg == '0)
    else $error("Grasp released without clearing the score.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_FINISH)
    else $error("Result item raised outside the final cycle.");

endmodule

[rtl/rpg_mac_lane.sv]
// Bit-serial multiply-accumulate lane: sums up to four signed products, one
// multiplier bit per cycle, with a right-shifting accumulator. Uses rpg_pkg.
module rpg_mac_lane
  import rpg_pkg::*;
#(
  parameter int AW = COORD_BITS_DEF + 1,
  parameter int MW = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [AW-1:0]     mcand [NTERMS],
  input  logic        [MW-1:0]     mplier [NTERMS],
  input  logic        [NTERMS-1:0] negate,
  output logic signed [AW+MW+3:0]  product
);

  localparam int HW = AW + 4;

  logic signed [HW-1:0] acc_hi;
  logic        [MW-1:0] acc_lo;
  logic signed [AW-1:0] a_reg [NTERMS];
  logic        [MW-1:0] m_reg [NTERMS];
  logic   [NTERMS-1:0]  neg_reg;
  logic signed [HW-1:0] term [NTERMS];
  logic signed [HW-1:0] sum;

  // The multiplier's top bit carries negative weight, so the last step flips the sign.
  always_comb begin
    sum = acc_hi;
    for (int k = 0; k < NTERMS; k++) begin
      if (!m_reg[k][0]) begin
        term[k] = '0;
      end else if (neg_reg[k] ^ ctl.last) begin
        term[k] = -HW'(a_reg[k]);
      end else begin
        term[k] = HW'(a_reg[k]);
      end
      sum = sum + term[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_hi <= '0;
      acc_lo <= '0;
      a_reg <= mcand;
      m_reg <= mplier;
      neg_reg <= negate;
    end else if (ctl.step) begin
      acc_hi <= sum >>> 1;
      acc_lo <= {sum[0], acc_lo[MW-1:1]};
      for (int k = 0; k < NTERMS; k++) begin
        m_reg[k] <= m_reg[k] >> 1;
      end
    end
  end

  assign product = {acc_hi, acc_lo};

endmodule
